### hw/rtl/ebca_pkg.sv
// Package with the operation codes, flag positions and item types of the ALU.
`timescale 1ns / 1ps
`default_nettype none

package ebca_pkg;

  localparam int KIND_W    = 5;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int BIDX_W    = 3;
  localparam int FLAGS_W   = 4;

  // Flag positions inside the packed flag nibble.
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 5'd0,
    KIND_ADC   = 5'd1,
    KIND_SUB   = 5'd2,
    KIND_SBC   = 5'd3,
    KIND_AND   = 5'd4,
    KIND_OR    = 5'd5,
    KIND_XOR   = 5'd6,
    KIND_CP    = 5'd7,
    KIND_INC8  = 5'd8,
    KIND_DEC8  = 5'd9,
    KIND_INC16 = 5'd10,
    KIND_DEC16 = 5'd11,
    KIND_ADDHL = 5'd12,
    KIND_ADDSP = 5'd13,
    KIND_RLC   = 5'd14,
    KIND_RL    = 5'd15,
    KIND_RRC   = 5'd16,
    KIND_RR    = 5'd17,
    KIND_SLA   = 5'd18,
    KIND_SRA   = 5'd19,
    KIND_SRL   = 5'd20,
    KIND_BIT   = 5'd21,
    KIND_SET   = 5'd22,
    KIND_RES   = 5'd23,
    KIND_SWAP  = 5'd24
  } kind_t;

  typedef logic [FLAGS_W-1:0] flags_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] accumulator;
    logic [WORD_W-1:0] operand;
    logic [WORD_W-1:0] wide_register;
    logic [BIDX_W-1:0] bit_index;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    flags_t            flags;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/ebca_if.sv
// Valid/ready channel interfaces for the ALU operation and result streams.
`timescale 1ns / 1ps
`default_nettype none

interface ebca_in_if
  import ebca_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] accumulator;
  logic [WORD_W-1:0] operand;
  logic [WORD_W-1:0] wide_register;
  logic [BIDX_W-1:0] bit_index;

  modport source (output valid, kind, accumulator, operand, wide_register, bit_index,
                  input ready);
  modport sink   (input valid, kind, accumulator, operand, wide_register, bit_index,
                  output ready);
endinterface

interface ebca_out_if
  import ebca_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  result;
  logic [FLAGS_W-1:0] flags_out;

  modport source (output valid, result, flags_out, input ready);
  modport sink   (input valid, result, flags_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/ebca_in_stage.sv
// Input register stage that captures one operation per transfer.
`timescale 1ns / 1ps
`default_nettype none

module ebca_in_stage
  import ebca_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ebca_in_if.sink    in_ch,
  input  wire logic  adv,
  output item_t      item,
  output logic       item_valid
);

  logic  valid_r;
  item_t item_r;
  logic  take;

  // The stage can take a new item when empty or when its item leaves this cycle.
  assign in_ch.ready = rst_n & (~valid_r | adv);
  assign take        = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.kind          <= in_ch.kind;
      item_r.accumulator   <= in_ch.accumulator;
      item_r.operand       <= in_ch.operand;
      item_r.wide_register <= in_ch.wide_register;
      item_r.bit_index     <= in_ch.bit_index;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

`default_nettype wire

### hw/rtl/ebca_core.sv
// Combinational ALU datapath that computes the result and the new flags.
`timescale 1ns / 1ps
`default_nettype none

module ebca_core
  import ebca_pkg::*;
(
  input  wire item_t  item,
  input  wire flags_t flags_in,
  output res_t        res
);

  function automatic logic zf(input logic [BYTE_W-1:0] v);
    zf = (v == '0);
  endfunction

  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [WORD_W-1:0] op;
  logic [WORD_W-1:0] wide;
  logic              cin;
  logic              t_add;
  logic              t_sub;
  logic [BYTE_W:0]   add9;
  logic [4:0]        addh5;
  logic [BYTE_W:0]   sub9;
  logic [4:0]        subh5;
  logic [BYTE_W-1:0] inc8;
  logic [BYTE_W-1:0] dec8;
  logic [WORD_W:0]   hl17;
  logic [12:0]       hlh13;
  logic [WORD_W-1:0] sp16;
  logic [4:0]        sph5;
  logic [BYTE_W:0]   spc9;
  logic [BYTE_W-1:0] bmask;
  logic [BYTE_W-1:0] r8;
  logic [WORD_W-1:0] r16;
  logic              use16;
  logic              fz, fn, fh, fc;

  assign a     = item.accumulator;
  assign op    = item.operand;
  assign b     = op[BYTE_W-1:0];
  assign wide  = item.wide_register;
  assign cin   = flags_in[FLAG_C];
  assign t_add = (item.kind == KIND_ADC) ? cin : 1'b0;
  assign t_sub = (item.kind == KIND_SBC) ? cin : 1'b0;

  assign add9  = {1'b0, a} + {1'b0, b} + {8'd0, t_add};
  assign addh5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t_add};
  // A borrow shows as the sign bit of the widened difference.
  assign sub9  = {1'b0, a} - {1'b0, b} - {8'd0, t_sub};
  assign subh5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t_sub};
  assign inc8  = b + 8'd1;
  assign dec8  = b - 8'd1;
  assign hl17  = {1'b0, wide} + {1'b0, op};
  assign hlh13 = {1'b0, wide[11:0]} + {1'b0, op[11:0]};
  assign sp16  = wide + {{8{b[7]}}, b};
  assign sph5  = {1'b0, wide[3:0]} + {1'b0, b[3:0]};
  assign spc9  = {1'b0, wide[7:0]} + {1'b0, b};
  assign bmask = 8'd1 << item.bit_index;

  always_comb begin
    r8    = '0;
    r16   = '0;
    use16 = 1'b0;
    fz    = flags_in[FLAG_Z];
    fn    = flags_in[FLAG_N];
    fh    = flags_in[FLAG_H];
    fc    = flags_in[FLAG_C];
    unique case (kind_t'(item.kind))
      KIND_ADD, KIND_ADC: begin
        r8 = add9[7:0];
        fz = zf(add9[7:0]); fn = 1'b0; fh = addh5[4]; fc = add9[8];
      end
      KIND_SUB, KIND_SBC, KIND_CP: begin
        r8 = (item.kind == KIND_CP) ? 8'd0 : sub9[7:0];
        fz = zf(sub9[7:0]); fn = 1'b1; fh = subh5[4]; fc = sub9[8];
      end
      KIND_AND: begin
        r8 = a & b;
        fz = zf(a & b); fn = 1'b0; fh = 1'b1; fc = 1'b0;
      end
      KIND_OR: begin
        r8 = a | b;
        fz = zf(a | b); fn = 1'b0; fh = 1'b0; fc = 1'b0;
      end
      KIND_XOR: begin
        r8 = a ^ b;
        fz = zf(a ^ b); fn = 1'b0; fh = 1'b0; fc = 1'b0;
      end
      KIND_INC8: begin
        r8 = inc8;
        fz = zf(inc8); fn = 1'b0; fh = (b[3:0] == 4'hF);
      end
      KIND_DEC8: begin
        r8 = dec8;
        fz = zf(dec8); fn = 1'b1; fh = (b[3:0] == 4'h0);
      end
      KIND_INC16: begin
        use16 = 1'b1; r16 = op + 16'd1;
      end
      KIND_DEC16: begin
        use16 = 1'b1; r16 = op - 16'd1;
      end
      KIND_ADDHL: begin
        use16 = 1'b1; r16 = hl17[15:0];
        fn = 1'b0; fh = hlh13[12]; fc = hl17[16];
      end
      KIND_ADDSP: begin
        use16 = 1'b1; r16 = sp16;
        fz = 1'b0; fn = 1'b0; fh = sph5[4]; fc = spc9[8];
      end
      KIND_RLC: begin
        r8 = {b[6:0], b[7]};
        fz = zf({b[6:0], b[7]}); fn = 1'b0; fh = 1'b0; fc = b[7];
      end
      KIND_RL: begin
        r8 = {b[6:0], cin};
        fz = zf({b[6:0], cin}); fn = 1'b0; fh = 1'b0; fc = b[7];
      end
      KIND_RRC: begin
        r8 = {b[0], b[7:1]};
        fz = zf({b[0], b[7:1]}); fn = 1'b0; fh = 1'b0; fc = b[0];
      end
      KIND_RR: begin
        r8 = {cin, b[7:1]};
        fz = zf({cin, b[7:1]}); fn = 1'b0; fh = 1'b0; fc = b[0];
      end
      KIND_SLA: begin
        r8 = {b[6:0], 1'b0};
        fz = zf({b[6:0], 1'b0}); fn = 1'b0; fh = 1'b0; fc = b[7];
      end
      KIND_SRA: begin
        r8 = {b[7], b[7:1]};
        fz = zf({b[7], b[7:1]}); fn = 1'b0; fh = 1'b0; fc = b[0];
      end
      KIND_SRL: begin
        r8 = {1'b0, b[7:1]};
        fz = zf({1'b0, b[7:1]}); fn = 1'b0; fh = 1'b0; fc = b[0];
      end
      KIND_BIT: begin
        fz = ~|(b & bmask); fn = 1'b0; fh = 1'b1;
      end
      KIND_SET: begin
        r8 = b | bmask;
      end
      KIND_RES: begin
        r8 = b & ~bmask;
      end
      KIND_SWAP: begin
        r8 = {b[3:0], b[7:4]};
        fz = zf(b); fn = 1'b0; fh = 1'b0; fc = 1'b0;
      end
      default: begin
        // Unused codes give a zero result and keep the flags.
      end
    endcase
  end

  assign res = {(use16 ? r16 : {8'd0, r8}), fz, fn, fh, fc};

endmodule

`default_nettype wire

### hw/rtl/eight_bit_cpu_alu_with_flags.sv
// Top level of the 8-bit CPU ALU with its Z/N/H/C flag register.
`timescale 1ns / 1ps
`default_nettype none

// This block is the ALU of a small 8-bit CPU. Each transfer on in_ch carries an
// operation code, the accumulator, a 16-bit operand, a 16-bit register (HL or SP)
// and a bit index; each transfer on out_ch returns the 16-bit result and the new
// flags packed as Z in bit 3, N in bit 2, H in bit 1 and C in bit 0. The flag
// register is internal: adc, sbc, rl and rr take their carry from it, and
// operations that keep some flags copy them from it. Reset clears all flags.
// An operation is held in the input register, passes through the combinational
// datapath and lands in the output register, from which out_ch shows its
// result. The block takes one operation every cycle for as long as the result
// side keeps taking results. The flag register is written at the same edge
// that loads the output register, so back-to-back operations always see the
// flags of the one before them. A stalled result does not block the input
// register from filling, and in_ch.ready combines the state of both stages
// with out_ch.ready. Unused operation codes return zero and leave the flags
// as they were.
module eight_bit_cpu_alu_with_flags
  import ebca_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ebca_in_if.sink    in_ch,
  ebca_out_if.source out_ch
);

  item_t  item;
  logic   item_valid;
  logic   adv;
  res_t   res;
  flags_t flags_r;
  res_t   out_res_r;
  logic   out_valid_r;

  // The held operation moves to the output register when that register is
  // empty or its result is being taken in this cycle.
  assign adv = item_valid & (~out_valid_r | out_ch.ready);

  ebca_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .adv        (adv),
    .item       (item),
    .item_valid (item_valid)
  );

  ebca_core u_core (
    .item     (item),
    .flags_in (flags_r),
    .res      (res)
  );

  // Control state: output valid and the architectural flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        flags_r     <= res.flags;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload only changes when a new result is loaded.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.result    = out_res_r.result;
  assign out_ch.flags_out = out_res_r.flags;

endmodule

`default_nettype wire

### hw/rtl/ebca_checker.sv
// Port-level assertions for the ALU, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ebca_checker
  import ebca_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [WORD_W-1:0]  out_result,
  input wire logic [FLAGS_W-1:0] out_flags
);

  // Every transfer in is followed by a valid result on the output.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result two cycles after an input transfer");

  // With nothing waiting at the output, the input side is never blocked.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while the output register is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result) && $stable(out_flags))
    else $error("result payload changed while stalled");

endmodule

bind eight_bit_cpu_alu_with_flags ebca_checker u_ebca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result),
  .out_flags  (out_ch.flags_out)
);

`default_nettype wire

### tb/ebca_alu_checker.sv
// Checker for the ALU: predicts each result from the accepted operations and compares.
`timescale 1ns / 1ps

module ebca_alu_checker
  import ebca_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ebca_in_if   in_mon,
  ebca_out_if  out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   checked
);

  // Our own copy of the flag register, advanced once per accepted operation.
  flags_t flag_shadow;
  res_t   pending_results[$];

  function automatic flags_t pack_flags(input logic z, input logic n, input logic h,
                                        input logic c);
    flags_t f;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

  function automatic res_t alu_outcome(input item_t op, input flags_t fl);
    res_t              o;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] r8;
    logic [BYTE_W-1:0] mask;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] v;
    logic              cin;
    logic              t;
    logic [4:0]        s5;
    logic [8:0]        s9;
    logic [12:0]       s13;
    logic [16:0]       s17;
    a    = op.accumulator;
    v    = op.operand;
    b    = v[7:0];
    w    = op.wide_register;
    cin  = fl[FLAG_C];
    mask = 8'd1 << op.bit_index;
    o.result = '0;
    o.flags  = fl;
    case (op.kind)
      KIND_ADD, KIND_ADC: begin
        t   = (op.kind == KIND_ADC) ? cin : 1'b0;
        s9  = {1'b0, a} + {1'b0, b} + {8'd0, t};
        s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
        r8  = s9[7:0];
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b0, s5[4], s9[8]);
      end
      KIND_SUB, KIND_SBC, KIND_CP: begin
        // Bit 4 and bit 8 of the widened differences are the borrows.
        t   = (op.kind == KIND_SBC) ? cin : 1'b0;
        s9  = {1'b0, a} - {1'b0, b} - {8'd0, t};
        s5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
        r8  = s9[7:0];
        o.result = (op.kind == KIND_CP) ? '0 : {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b1, s5[4], s9[8]);
      end
      KIND_AND: begin
        r8 = a & b;
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      KIND_OR, KIND_XOR: begin
        r8 = (op.kind == KIND_OR) ? (a | b) : (a ^ b);
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      KIND_INC8: begin
        r8 = b + 8'd1;
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b0, b[3:0] == 4'hF, cin);
      end
      KIND_DEC8: begin
        r8 = b - 8'd1;
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b1, b[3:0] == 4'h0, cin);
      end
      KIND_INC16: o.result = v + 16'd1;
      KIND_DEC16: o.result = v - 16'd1;
      KIND_ADDHL: begin
        s17 = {1'b0, w} + {1'b0, v};
        s13 = {1'b0, w[11:0]} + {1'b0, v[11:0]};
        o.result = s17[15:0];
        o.flags  = pack_flags(fl[FLAG_Z], 1'b0, s13[12], s17[16]);
      end
      KIND_ADDSP: begin
        // The sum uses the sign-extended offset; the flags use unsigned low-byte carries.
        o.result = w + {{8{b[7]}}, b};
        s5  = {1'b0, w[3:0]} + {1'b0, b[3:0]};
        s9  = {1'b0, w[7:0]} + {1'b0, b};
        o.flags  = pack_flags(1'b0, 1'b0, s5[4], s9[8]);
      end
      KIND_RLC, KIND_RL, KIND_SLA: begin
        case (op.kind)
          KIND_RLC: r8 = {b[6:0], b[7]};
          KIND_RL:  r8 = {b[6:0], cin};
          default:  r8 = {b[6:0], 1'b0};
        endcase
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b0, 1'b0, b[7]);
      end
      KIND_RRC, KIND_RR, KIND_SRA, KIND_SRL: begin
        case (op.kind)
          KIND_RRC: r8 = {b[0], b[7:1]};
          KIND_RR:  r8 = {cin, b[7:1]};
          KIND_SRA: r8 = {b[7], b[7:1]};
          default:  r8 = {1'b0, b[7:1]};
        endcase
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b0, 1'b0, b[0]);
      end
      KIND_BIT:  o.flags  = pack_flags((b & mask) == 8'h00, 1'b0, 1'b1, cin);
      KIND_SET:  o.result = {8'h00, b | mask};
      KIND_RES:  o.result = {8'h00, b & ~mask};
      KIND_SWAP: begin
        o.result = {8'h00, b[3:0], b[7:4]};
        o.flags  = pack_flags(b == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : track
    item_t op;
    res_t  want;
    if (!rst_n) begin
      flag_shadow = '0;
      pending_results.delete();
      mismatches  = 0;
      checked     = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        op.kind          = in_mon.kind;
        op.accumulator   = in_mon.accumulator;
        op.operand       = in_mon.operand;
        op.wide_register = in_mon.wide_register;
        op.bit_index     = in_mon.bit_index;
        want        = alu_outcome(op, flag_shadow);
        flag_shadow = want.flags;
        pending_results.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: result %h, flags_out %h",
                 out_mon.result, out_mon.flags_out);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (out_mon.result !== want.result) begin
            $error("result: expected %h, actual %h", want.result, out_mon.result);
            mismatches++;
          end
          if (out_mon.flags_out !== want.flags) begin
            $error("flags_out: expected %b, actual %b", want.flags, out_mon.flags_out);
            mismatches++;
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

### tb/tb_eight_bit_cpu_alu_with_flags.sv
// Top of the ALU testbench: clock, reset, operation stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module tb_eight_bit_cpu_alu_with_flags;
  import ebca_pkg::*;

  // Codes past the last defined operation. The block must return zero for them
  // and leave the flags alone, so they are part of the stimulus too.
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 5'd25;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 5'd31;

  localparam int RANDOM_OPS  = 1525;
  localparam int BURST_LEN   = 50;
  localparam int STALL_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n;

  // When set, neither side inserts gaps, so the block runs at full rate.
  logic steady = 1'b0;

  int ops_sent;
  int directed_count;
  int mismatches;
  int outstanding;
  int checked;

  ebca_in_if  in_ch ();
  ebca_out_if out_ch ();

  eight_bit_cpu_alu_with_flags DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ebca_alu_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always #5 clk = ~clk;

  function automatic item_t mk(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] a,
                               input logic [WORD_W-1:0] v, input logic [WORD_W-1:0] w,
                               input logic [BIDX_W-1:0] idx);
    item_t it;
    it.kind          = kind;
    it.accumulator   = a;
    it.operand       = v;
    it.wide_register = w;
    it.bit_index     = idx;
    return it;
  endfunction

  // Random bytes lean toward the values where carries, borrows and zero flags flip.
  function automatic logic [BYTE_W-1:0] rand_byte();
    if ($urandom_range(0, 3) != 0) begin
      return BYTE_W'($urandom);
    end
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h0F;
      3:       return 8'hF0;
      4:       return 8'h80;
      5:       return 8'h7F;
      6:       return 8'h01;
      default: return 8'h10;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 16'h0FFF;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      default: return {rand_byte(), rand_byte()};
    endcase
  endfunction

  // Offers one operation on the input channel, starting at a falling edge. A random
  // gap with valid low comes first; then the operation is held until the block
  // takes it. The task returns at the falling edge after the transfer.
  task automatic push_op(input item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= it.kind;
    in_ch.accumulator   <= it.accumulator;
    in_ch.operand       <= it.operand;
    in_ch.wide_register <= it.wide_register;
    in_ch.bit_index     <= it.bit_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ops_sent++;
    @(negedge clk);
  endtask

  // Result side: after every result transfer, ready drops for a random stall.
  initial begin : result_taker
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: when the run of idle clocks with no transfer on either channel
  // reaches STALL_LIMIT, the block is taken to have hung.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no transfer for %0d cycles, %0d results still due.",
             STALL_LIMIT, outstanding);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    item_t directed[$];
    item_t it;
    ops_sent            = 0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = '0;
    in_ch.accumulator   = '0;
    in_ch.operand       = '0;
    in_ch.wide_register = '0;
    in_ch.bit_index     = '0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The order matters where the carry flag feeds the next
    // operation: add sets C for adc, sub sets it for the first sbc, rlc and rrc
    // set it for rl and rr.
    directed.push_back(mk(KIND_ADD,   8'hFF, 16'hAB01, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_ADC,   8'h0F, 16'hFF00, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_SUB,   8'h00, 16'h0001, 16'h0000, 3'd0));
    // With the carry in, 0 - 0 - 1 wraps to FF and must not read as zero,
    // while 1 - 0 - 1 gives a zero byte.
    directed.push_back(mk(KIND_SBC,   8'h00, 16'h0000, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_SBC,   8'h01, 16'h0000, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_AND,   8'hF0, 16'h000F, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_OR,    8'h00, 16'hFF00, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_XOR,   8'hFF, 16'h00FF, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_CP,    8'h42, 16'h0042, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_INC8,  8'h00, 16'hFFFF, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_DEC8,  8'h00, 16'hFF00, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_INC16, 8'h00, 16'hFFFF, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_DEC16, 8'h00, 16'h0000, 16'h0000, 3'd0));
    // Half carry of the 16-bit add comes out of bit 11.
    directed.push_back(mk(KIND_ADDHL, 8'h00, 16'h0001, 16'h0FFF, 3'd0));
    directed.push_back(mk(KIND_ADDHL, 8'h00, 16'hFFFF, 16'hFFFF, 3'd0));
    // Stack pointer offsets: carries from the low byte, a negative offset with
    // a high byte in the operand that must be ignored.
    directed.push_back(mk(KIND_ADDSP, 8'h00, 16'h0001, 16'h00FF, 3'd0));
    directed.push_back(mk(KIND_ADDSP, 8'h00, 16'hFF80, 16'h1000, 3'd0));
    directed.push_back(mk(KIND_RLC,   8'h00, 16'h0080, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_RL,    8'h00, 16'h0000, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_RRC,   8'h00, 16'h0001, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_RR,    8'h00, 16'h0000, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_SLA,   8'h00, 16'h0080, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_SRA,   8'h00, 16'h0081, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_SRL,   8'h00, 16'h0001, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_BIT,   8'h00, 16'h0080, 16'h0000, 3'd7));
    directed.push_back(mk(KIND_SET,   8'h00, 16'h0000, 16'h0000, 3'd7));
    directed.push_back(mk(KIND_RES,   8'h00, 16'h00FF, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_SWAP,  8'h00, 16'hFF00, 16'h0000, 3'd0));
    directed.push_back(mk(KIND_UNUSED_LO, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7));
    directed_count = directed.size();
    foreach (directed[i]) push_op(directed[i]);

    // Random part, in bursts. About a quarter of the bursts run without gaps on
    // either side; the rest draw a fresh gap for every operation and result.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % BURST_LEN == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 29) == 0) begin
        it.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      end else begin
        it.kind = KIND_W'($urandom_range(KIND_ADD, KIND_SWAP));
      end
      it.accumulator   = rand_byte();
      it.operand       = rand_word();
      it.wide_register = rand_word();
      it.bit_index     = BIDX_W'($urandom);
      push_op(it);
    end
    in_ch.valid <= 1'b0;
    steady = 1'b0;

    // Drain: wait for every predicted result, then keep the clock running so that a
    // stray extra result would still be caught by the checker.
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d operations: %0d directed corner cases, then random traffic",
             ops_sent, directed_count);
    $display("over all codes including unused ones; %0d results compared, %0d mismatches.",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
